[hdl/tlca_pkg.sv]
package tlca_pkg;

    // fixed field widths
    localparam int ACT_W = 2;
    localparam int ID_W  = 10;
    localparam int CNT_W = 11;
    localparam int ST_W  = 2;

    // parameter defaults and register reset
    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 11;
    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    // msb search masks
    localparam logic [31:0] MASK_HI16 = 32'hFFFF0000;
    localparam logic [31:0] MASK_HI8  = 32'h0000FF00;
    localparam logic [31:0] MASK_HI4  = 32'h000000F0;
    localparam logic [1:0] LOW_MSB [16] = '{
        2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
    };

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_BUILD = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_BUILT = 2'd1,
        ST_BAD_NODE  = 2'd2,
        ST_NO_ROOT   = 2'd3
    } t_status;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SWEEP_TREE,
        OP_EDGE_RD,
        OP_EDGE_WR,
        OP_SWEEP_VIS,
        OP_ROOT_RD,
        OP_ROOT_NEXT,
        OP_WALK_START,
        OP_WALK_RD,
        OP_WALK_GET,
        OP_WALK_ENTER,
        OP_WALK_LEAVE,
        OP_WALK_CHILD,
        OP_WALK_NEXT,
        OP_FILL_INIT,
        OP_FILL_RA,
        OP_FILL_RB,
        OP_FILL_WR,
        OP_FILL_LVL,
        OP_Q_RDA,
        OP_Q_RDB,
        OP_Q_CHK,
        OP_Q_RD1,
        OP_Q_RD2,
        OP_Q_CMP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic edge_ok;
        logic idx_ge_cnt;
        logic root_hp;
        logic sp_zero;
        logic vis_s;
        logic c_nil;
        logic fill_ok;
        logic lvl_last;
        logic q_in_range;
        logic q_ok;
        logic out_free;
    } t_flags;

    // index of the most significant set bit, x nonzero
    function automatic logic [4:0] top_bit(input logic [31:0] x);
        logic [31:0] v;
        logic [4:0]  r;
        v = x;
        r = 5'd0;
        if ((v & MASK_HI16) != 32'd0) begin
            r = r + 5'd16;
            v = v >> 16;
        end
        if ((v & MASK_HI8) != 32'd0) begin
            r = r + 5'd8;
            v = v >> 8;
        end
        if ((v & MASK_HI4) != 32'd0) begin
            r = r + 5'd4;
            v = v >> 4;
        end
        return r + 5'(LOW_MSB[v[3:0]]);
    endfunction

endpackage

[hdl/tlca_ram.sv]
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tlca_ctrl.sv]
module tlca_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [tlca_pkg::ACT_W-1:0]  i_action,
    output logic                        o_ready,
    output tlca_pkg::t_cmd              o_cmd,
    input  tlca_pkg::t_flags            i_flags
);
    import tlca_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR, S_EDGE_RD, S_EDGE_WR,
        S_VCLR, S_ROOT_RD, S_ROOT_CHK,
        S_WALK_RD, S_WALK_GET, S_WALK_DEC, S_WALK_CHILD, S_WALK_NEXT,
        S_FILL_INIT, S_FILL_CHK, S_FILL_RB, S_FILL_WR,
        S_Q_START, S_Q_B, S_Q_CHK, S_Q_R1, S_Q_R2, S_Q_CMP,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_built, n_built;
    t_op     w_op;

    // next state and datapath operation
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_built = r_built;
        w_op    = OP_NONE;
        unique case (r_state)
            S_INIT: begin
                w_op = OP_SWEEP_TREE;
                if (i_flags.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    w_op   = OP_LOAD;
                    n_code = ST_OK;
                    unique case (t_action'(i_action))
                        ACT_CLEAR: begin
                            n_state = S_CLR;
                            n_built = 1'b0;
                        end
                        ACT_EDGE:  n_state = S_EDGE_RD;
                        ACT_BUILD: begin
                            n_state = S_VCLR;
                            n_built = 1'b0;
                        end
                        ACT_QUERY: n_state = S_Q_START;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                w_op = OP_SWEEP_TREE;
                if (i_flags.sweep_last) n_state = S_DONE;
            end
            S_EDGE_RD: begin
                w_op    = OP_EDGE_RD;
                n_state = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                if (i_flags.edge_ok) begin
                    w_op    = OP_EDGE_WR;
                    n_built = 1'b0;
                end else begin
                    n_code = ST_BAD_NODE;
                end
                n_state = S_DONE;
            end
            S_VCLR: begin
                w_op = OP_SWEEP_VIS;
                if (i_flags.sweep_last) n_state = S_ROOT_RD;
            end
            S_ROOT_RD: begin
                if (i_flags.idx_ge_cnt) begin
                    n_code  = ST_NO_ROOT;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_ROOT_RD;
                    n_state = S_ROOT_CHK;
                end
            end
            S_ROOT_CHK: begin
                if (i_flags.root_hp) begin
                    w_op    = OP_ROOT_NEXT;
                    n_state = S_ROOT_RD;
                end else begin
                    w_op    = OP_WALK_START;
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (i_flags.sp_zero) begin
                    n_state = S_FILL_INIT;
                end else begin
                    w_op    = OP_WALK_RD;
                    n_state = S_WALK_GET;
                end
            end
            S_WALK_GET: begin
                w_op    = OP_WALK_GET;
                n_state = S_WALK_DEC;
            end
            S_WALK_DEC: begin
                if (i_flags.vis_s) begin
                    w_op    = OP_WALK_LEAVE;
                    n_state = S_WALK_RD;
                end else begin
                    w_op    = OP_WALK_ENTER;
                    n_state = S_WALK_CHILD;
                end
            end
            S_WALK_CHILD: begin
                if (i_flags.c_nil) begin
                    n_state = S_WALK_RD;
                end else begin
                    w_op    = OP_WALK_CHILD;
                    n_state = S_WALK_NEXT;
                end
            end
            S_WALK_NEXT: begin
                w_op    = OP_WALK_NEXT;
                n_state = S_WALK_CHILD;
            end
            S_FILL_INIT: begin
                w_op    = OP_FILL_INIT;
                n_state = S_FILL_CHK;
            end
            S_FILL_CHK: begin
                if (i_flags.fill_ok) begin
                    w_op    = OP_FILL_RA;
                    n_state = S_FILL_RB;
                end else if (i_flags.lvl_last) begin
                    n_built = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_op = OP_FILL_LVL;
                end
            end
            S_FILL_RB: begin
                w_op    = OP_FILL_RB;
                n_state = S_FILL_WR;
            end
            S_FILL_WR: begin
                w_op    = OP_FILL_WR;
                n_state = S_FILL_CHK;
            end
            S_Q_START: begin
                if (!r_built) begin
                    n_code  = ST_NOT_BUILT;
                    n_state = S_DONE;
                end else if (!i_flags.q_in_range) begin
                    n_code  = ST_BAD_NODE;
                    n_state = S_DONE;
                end else begin
                    w_op    = OP_Q_RDA;
                    n_state = S_Q_B;
                end
            end
            S_Q_B: begin
                w_op    = OP_Q_RDB;
                n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                if (i_flags.q_ok) begin
                    w_op    = OP_Q_CHK;
                    n_state = S_Q_R1;
                end else begin
                    n_code  = ST_BAD_NODE;
                    n_state = S_DONE;
                end
            end
            S_Q_R1: begin
                w_op    = OP_Q_RD1;
                n_state = S_Q_R2;
            end
            S_Q_R2: begin
                w_op    = OP_Q_RD2;
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                w_op    = OP_Q_CMP;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    w_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_code  <= ST_OK;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_built <= n_built;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_cmd.op   = w_op;
    assign o_cmd.code = r_code;

endmodule

[hdl/tlca_dp.sv]
module tlca_dp #(
    parameter int NODES  = tlca_pkg::NODES_DEF,
    parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tlca_pkg::CNT_W-1:0] i_cfg_data,
    input  logic [tlca_pkg::ID_W-1:0]  i_first_node,
    input  logic [tlca_pkg::ID_W-1:0]  i_second_node,
    input  tlca_pkg::t_cmd             i_cmd,
    output tlca_pkg::t_flags           o_flags,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [tlca_pkg::ID_W-1:0]  o_ancestor,
    output logic [tlca_pkg::ST_W-1:0]  o_status
);
    import tlca_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int IW  = NW + 1;
    localparam int TW  = NW + 1;
    localparam int LW  = $clog2(LEVELS);
    localparam int EW  = 2 * NW;
    localparam int CW  = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;
    localparam int TAW = LW + TW;
    localparam int TAB_DEPTH = 1 << TAW;
    localparam logic [IW-1:0] NODE_NIL = {1'b1, {NW{1'b0}}};

    // registers
    logic [CNT_W-1:0] r_nc;
    logic [ID_W-1:0]  r_a, r_b;
    logic [IW-1:0]    r_idx, r_sp, r_c;
    logic [TW-1:0]    r_pos, r_tlen, r_n, r_fa, r_lo, r_hi;
    logic [NW-1:0]    r_s, r_sdep, r_anc;
    logic [LW-1:0]    r_lvl, r_k;
    logic [TW:0]      r_w2;
    logic [EW-1:0]    r_ea;
    logic             r_va;
    logic             r_ovalid;
    logic [ID_W-1:0]  r_oanc;
    t_status          r_ost;

    // memory ports
    logic          fc_we, hp_we, ns_we, vis_we, par_we, dep_we, ftp_we, stk_we, tab_we;
    logic [NW-1:0] fc_wa, hp_wa, ns_wa, vis_wa, par_wa, dep_wa, ftp_wa, stk_wa;
    logic [NW-1:0] fc_ra, hp_ra, ns_ra, vis_ra, par_ra, dep_ra, ftp_ra, stk_ra;
    logic [IW-1:0] fc_wd, ns_wd, par_wd, fc_rd, ns_rd, par_rd;
    logic          hp_wd, vis_wd, hp_rd, vis_rd;
    logic [NW-1:0] dep_wd, stk_wd, dep_rd, stk_rd;
    logic [TW-1:0] ftp_wd, ftp_rd;
    logic [TAW-1:0] tab_wa, tab_ra;
    logic [EW-1:0]  tab_wd, tab_rd;

    // helpers
    logic [CW-1:0] w_nc_ext, w_cnt;
    logic          w_a_ok, w_b_ok, w_c_ok;
    logic          w_sweep_last;
    logic [TW-1:0] w_lo, w_hi, w_fill_b, w_q_t;
    logic [TW:0]   w_len, w_pow;
    logic [4:0]    w_kraw;
    logic [LW-1:0] w_k, w_lvl_prev;
    logic [EW-1:0] w_fill_min;
    logic [NW-1:0] w_q_min;

    assign w_nc_ext     = CW'(r_nc);
    assign w_cnt        = (w_nc_ext < CW'(NODES)) ? w_nc_ext : CW'(NODES);
    assign w_a_ok       = CW'(r_a) < w_cnt;
    assign w_b_ok       = CW'(r_b) < w_cnt;
    assign w_c_ok       = CW'(r_c[NW-1:0]) < w_cnt;
    assign w_sweep_last = (r_idx == IW'(NODES - 1));
    assign w_lvl_prev   = r_lvl - LW'(1);

    // query window: order the first positions, size by range msb
    assign w_lo   = (r_fa > ftp_rd) ? ftp_rd : r_fa;
    assign w_hi   = (r_fa > ftp_rd) ? r_fa : ftp_rd;
    assign w_len  = (TW+1)'(w_hi) - (TW+1)'(w_lo) + (TW+1)'(1);
    assign w_kraw = top_bit(32'(w_len));
    assign w_k    = (w_kraw > 5'(LEVELS - 1)) ? LW'(LEVELS - 1) : w_kraw[LW-1:0];
    assign w_pow  = (TW+1)'(1) << r_k;
    assign w_q_t  = TW'((TW+1)'(r_hi) + (TW+1)'(1) - w_pow);

    // table entry is {depth, node}
    assign w_fill_b   = r_n + TW'(r_w2 >> 1);
    assign w_fill_min = (tab_rd[EW-1:NW] < r_ea[EW-1:NW]) ? tab_rd : r_ea;
    assign w_q_min    = (r_ea[EW-1:NW] < tab_rd[EW-1:NW]) ? r_ea[NW-1:0]
                                                          : tab_rd[NW-1:0];

    // memory address and write selection
    always_comb begin
        fc_we = 1'b0;  fc_wa = '0;  fc_wd = '0;  fc_ra = '0;
        hp_we = 1'b0;  hp_wa = '0;  hp_wd = 1'b0; hp_ra = '0;
        ns_we = 1'b0;  ns_wa = '0;  ns_wd = '0;  ns_ra = '0;
        vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0; vis_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
        dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_ra = '0;
        ftp_we = 1'b0; ftp_wa = '0; ftp_wd = '0; ftp_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
        tab_we = 1'b0; tab_wa = '0; tab_wd = '0; tab_ra = '0;
        unique case (i_cmd.op)
            OP_SWEEP_TREE: begin
                fc_we = 1'b1; fc_wa = r_idx[NW-1:0]; fc_wd = NODE_NIL;
                hp_we = 1'b1; hp_wa = r_idx[NW-1:0]; hp_wd = 1'b0;
            end
            OP_EDGE_RD: begin
                hp_ra = NW'(r_b);
                fc_ra = NW'(r_a);
            end
            OP_EDGE_WR: begin
                hp_we = 1'b1; hp_wa = NW'(r_b); hp_wd = 1'b1;
                ns_we = 1'b1; ns_wa = NW'(r_b); ns_wd = fc_rd;
                fc_we = 1'b1; fc_wa = NW'(r_a); fc_wd = {1'b0, NW'(r_b)};
            end
            OP_SWEEP_VIS: begin
                vis_we = 1'b1; vis_wa = r_idx[NW-1:0]; vis_wd = 1'b0;
            end
            OP_ROOT_RD: hp_ra = r_idx[NW-1:0];
            OP_WALK_START: begin
                stk_we = 1'b1; stk_wa = '0;             stk_wd = r_idx[NW-1:0];
                par_we = 1'b1; par_wa = r_idx[NW-1:0]; par_wd = NODE_NIL;
                dep_we = 1'b1; dep_wa = r_idx[NW-1:0]; dep_wd = '0;
            end
            OP_WALK_RD: stk_ra = NW'(r_sp - IW'(1));
            OP_WALK_GET: begin
                vis_ra = stk_rd;
                dep_ra = stk_rd;
                par_ra = stk_rd;
                fc_ra  = stk_rd;
            end
            OP_WALK_ENTER: begin
                vis_we = 1'b1; vis_wa = r_s; vis_wd = 1'b1;
                ftp_we = 1'b1; ftp_wa = r_s; ftp_wd = r_pos;
                tab_we = 1'b1; tab_wa = {LW'(0), r_pos}; tab_wd = {dep_rd, r_s};
            end
            OP_WALK_LEAVE: begin
                if (!par_rd[NW]) begin
                    tab_we = 1'b1;
                    tab_wa = {LW'(0), r_pos};
                    tab_wd = {dep_rd - NW'(1), par_rd[NW-1:0]};
                end
            end
            OP_WALK_CHILD: begin
                if (w_c_ok) begin
                    par_we = 1'b1; par_wa = r_c[NW-1:0]; par_wd = {1'b0, r_s};
                    dep_we = 1'b1; dep_wa = r_c[NW-1:0]; dep_wd = r_sdep + NW'(1);
                    stk_we = 1'b1; stk_wa = r_sp[NW-1:0]; stk_wd = r_c[NW-1:0];
                end
                ns_ra = r_c[NW-1:0];
            end
            OP_FILL_RA: tab_ra = {w_lvl_prev, r_n};
            OP_FILL_RB: tab_ra = {w_lvl_prev, w_fill_b};
            OP_FILL_WR: begin
                tab_we = 1'b1; tab_wa = {r_lvl, r_n}; tab_wd = w_fill_min;
            end
            OP_Q_RDA: begin
                vis_ra = NW'(r_a);
                ftp_ra = NW'(r_a);
            end
            OP_Q_RDB: begin
                vis_ra = NW'(r_b);
                ftp_ra = NW'(r_b);
            end
            OP_Q_RD1: tab_ra = {r_k, r_lo};
            OP_Q_RD2: tab_ra = {r_k, w_q_t};
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc     <= COUNT_RESET;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_nc <= i_cfg_data;
            case (i_cmd.op)
                OP_LOAD:                    r_idx <= '0;
                OP_SWEEP_TREE, OP_SWEEP_VIS: r_idx <= w_sweep_last ? '0 : r_idx + IW'(1);
                OP_ROOT_NEXT:               r_idx <= r_idx + IW'(1);
                default: ;
            endcase
            if (i_cmd.op == OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers of the walk, fill and query
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a   <= i_first_node;
                r_b   <= i_second_node;
                r_anc <= '0;
            end
            OP_WALK_START: begin
                r_sp  <= IW'(1);
                r_pos <= '0;
                r_anc <= r_idx[NW-1:0];
            end
            OP_WALK_GET: r_s <= stk_rd;
            OP_WALK_ENTER: begin
                r_pos  <= r_pos + TW'(1);
                r_c    <= fc_rd;
                r_sdep <= dep_rd;
            end
            OP_WALK_LEAVE: begin
                r_sp <= r_sp - IW'(1);
                if (!par_rd[NW]) r_pos <= r_pos + TW'(1);
            end
            OP_WALK_CHILD: if (w_c_ok) r_sp <= r_sp + IW'(1);
            OP_WALK_NEXT: r_c <= ns_rd;
            OP_FILL_INIT: begin
                r_tlen <= r_pos;
                r_lvl  <= LW'(1);
                r_w2   <= (TW+1)'(2);
                r_n    <= '0;
            end
            OP_FILL_RB: r_ea <= tab_rd;
            OP_FILL_WR: r_n <= r_n + TW'(1);
            OP_FILL_LVL: begin
                r_lvl <= r_lvl + LW'(1);
                r_w2  <= r_w2[TW] ? r_w2 : (r_w2 << 1);
                r_n   <= '0;
            end
            OP_Q_RDB: begin
                r_va <= vis_rd;
                r_fa <= ftp_rd;
            end
            OP_Q_CHK: begin
                r_lo <= w_lo;
                r_hi <= w_hi;
                r_k  <= w_k;
            end
            OP_Q_RD2: r_ea <= tab_rd;
            OP_Q_CMP: r_anc <= w_q_min;
            OP_EMIT: begin
                r_oanc <= ID_W'(r_anc);
                r_ost  <= i_cmd.code;
            end
            default: ;
        endcase
    end

    // status toward the controller
    assign o_flags.sweep_last = w_sweep_last;
    assign o_flags.edge_ok    = w_a_ok && w_b_ok && (r_a != r_b) && !hp_rd;
    assign o_flags.idx_ge_cnt = CW'(r_idx) >= w_cnt;
    assign o_flags.root_hp    = hp_rd;
    assign o_flags.sp_zero    = (r_sp == '0);
    assign o_flags.vis_s      = vis_rd;
    assign o_flags.c_nil      = r_c[NW];
    assign o_flags.fill_ok    = ((TW+2)'(r_n) + (TW+2)'(r_w2)) <= (TW+2)'(r_tlen);
    assign o_flags.lvl_last   = (r_lvl == LW'(LEVELS - 1));
    assign o_flags.q_in_range = w_a_ok && w_b_ok;
    assign o_flags.q_ok       = r_va && vis_rd && (w_hi < r_tlen);
    assign o_flags.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_ancestor  = r_oanc;
    assign o_status    = r_ost;

    // per-node stores
    tlca_ram #(.WIDTH(IW), .DEPTH(NODES)) u_fc (
        .i_clk(i_clk), .i_we(fc_we), .i_waddr(fc_wa), .i_wdata(fc_wd),
        .i_raddr(fc_ra), .o_rdata(fc_rd));
    tlca_ram #(.WIDTH(1), .DEPTH(NODES)) u_hp (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_wa), .i_wdata(hp_wd),
        .i_raddr(hp_ra), .o_rdata(hp_rd));
    tlca_ram #(.WIDTH(IW), .DEPTH(NODES)) u_ns (
        .i_clk(i_clk), .i_we(ns_we), .i_waddr(ns_wa), .i_wdata(ns_wd),
        .i_raddr(ns_ra), .o_rdata(ns_rd));
    tlca_ram #(.WIDTH(1), .DEPTH(NODES)) u_vis (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_wa), .i_wdata(vis_wd),
        .i_raddr(vis_ra), .o_rdata(vis_rd));
    tlca_ram #(.WIDTH(IW), .DEPTH(NODES)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(par_ra), .o_rdata(par_rd));
    tlca_ram #(.WIDTH(NW), .DEPTH(NODES)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_wa), .i_wdata(dep_wd),
        .i_raddr(dep_ra), .o_rdata(dep_rd));
    tlca_ram #(.WIDTH(TW), .DEPTH(NODES)) u_ftp (
        .i_clk(i_clk), .i_we(ftp_we), .i_waddr(ftp_wa), .i_wdata(ftp_wd),
        .i_raddr(ftp_ra), .o_rdata(ftp_rd));
    tlca_ram #(.WIDTH(NW), .DEPTH(NODES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    // sparse table, level-major
    tlca_ram #(.WIDTH(EW), .DEPTH(TAB_DEPTH)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_wa), .i_wdata(tab_wd),
        .i_raddr(tab_ra), .o_rdata(tab_rd));

endmodule

[hdl/tree_lca_sparse_table_top.sv]
// Lowest-common-ancestor engine for a rooted tree of up to NODES nodes. Each input
// item clears the tree, adds a parent-child edge, builds the tables, or queries a
// node pair; every item gives exactly one result item (ancestor, status). Items are
// handled one at a time by a controller and a datapath with RAMs that have one write
// port and one registered read port. After reset the block sweeps the tree store
// before it takes its first item. A query is a chain of dependent RAM reads (first
// positions, then two table windows). Build clears the visited marks, tests nodes
// for a root, walks the tree depth first from it, then fills the sparse table level
// by level. A finished result waits in an output register, so the next item is
// taken while it is still held.
module tree_lca_sparse_table_top #(
    parameter int NODES  = tlca_pkg::NODES_DEF,
    parameter int LEVELS = tlca_pkg::LEVELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tlca_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [tlca_pkg::ACT_W-1:0] i_action,
    input  logic [tlca_pkg::ID_W-1:0]  i_first_node,
    input  logic [tlca_pkg::ID_W-1:0]  i_second_node,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [tlca_pkg::ID_W-1:0]  o_ancestor,
    output logic [tlca_pkg::ST_W-1:0]  o_status
);
    import tlca_pkg::*;

    t_cmd   w_cmd;
    t_flags w_flags;

    // sequencer
    tlca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd),
        .i_flags  (w_flags)
    );

    // stores, walk, table fill and query arithmetic
    tlca_dp #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_first_node  (i_first_node),
        .i_second_node (i_second_node),
        .i_cmd         (w_cmd),
        .o_flags       (w_flags),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_ancestor    (o_ancestor),
        .o_status      (o_status)
    );

    // a failed item never reports an ancestor
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_ancestor == '0))
        else $error("nonzero ancestor with failing status");

    // one item at a time: accepting an item drops ready
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after item accepted");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_EMIT) |-> (!o_valid || i_ready))
        else $error("result overwrote a pending item");

endmodule
